/* rtl/core/assert_macros.svh */
// Assertion macros shared by the indexed list engine RTL.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked outside reset.
`define ILE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle.
`define ILE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ile_pkg.sv */
// Package for the indexed list engine: request codes, command and state types, payload structs.
// No dependencies.
package ile_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int Q_DEPTH      = 2;
    localparam int Q_AW         = $clog2(Q_DEPTH);

    localparam logic [2:0] REQ_APPEND    = 3'd0;
    localparam logic [2:0] REQ_PREPEND   = 3'd1;
    localparam logic [2:0] REQ_INSERT    = 3'd2;
    localparam logic [2:0] REQ_OVERWRITE = 3'd3;
    localparam logic [2:0] REQ_SWAP      = 3'd4;
    localparam logic [2:0] REQ_CLEAR     = 3'd5;
    localparam logic [2:0] REQ_READ      = 3'd6;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [6:0]        index_a;
        logic [6:0]        index_b;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic               accepted;
        logic [6:0]         element_count;
        logic               is_empty;
        logic signed [31:0] read_value;
    } t_result;

    // Prepend is folded into insert at index zero.
    typedef enum logic [2:0] {
        C_APPEND,
        C_INSERT,
        C_OVERWRITE,
        C_SWAP,
        C_CLEAR,
        C_READ,
        C_BAD
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [6:0]  ia;
        logic [6:0]  ib;
        logic [31:0] val;
    } t_cmd_item;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SHIFT_RD,
        B_SHIFT_WR,
        B_FILL,
        B_PUT,
        B_SWAP_RB,
        B_SWAP_WA,
        B_SWAP_WB,
        B_READ
    } t_back_state;

endpackage

/* rtl/core/indexed_list_engine_top.sv */
// Indexed list engine: ordered list of signed 32-bit values with a count.
// A request passes the front register and the command queue; o_done and o_res are registered.
// Append/overwrite/clear/reject finish when taken; read waits on the store read; swap reads and writes
// both; insert moves entries above i up (read, write) on the one store port, or fills up to i.
// Up to three requests are buffered; busy rises when front register and queue are full.
// Reset is synchronous, active low, and empties the list; stored values are not cleared.
module indexed_list_engine_top import ile_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_done,
    output t_result o_res
);

    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;
    t_cmd_item front_item;
    t_cmd_item head_item;

    ile_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_busy   (busy),
        .o_push   (push),
        .o_item   (front_item)
    );

    ile_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_item)
    );

    ile_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_item),
        .o_pop   (pop),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule

/* rtl/core/ile_front.sv */
// Front end of the indexed list engine: takes requests, decodes them into commands.
// Depends on ile_pkg.
module ile_front import ile_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_req      i_req,
    input  logic      i_q_full,
    output logic      o_busy,
    output logic      o_push,
    output t_cmd_item o_item
);

    logic      r_valid;
    logic      n_valid;
    t_cmd_item r_item;
    t_cmd_item n_item;
    logic      accept;

    assign o_push = r_valid && !i_q_full;
    assign o_busy = r_valid && i_q_full;
    assign accept = i_start && !o_busy;
    assign o_item = r_item;

    always_comb begin
        n_valid = accept ? 1'b1 : (o_push ? 1'b0 : r_valid);
    end

    always_comb begin
        n_item.ia  = i_req.index_a;
        n_item.ib  = i_req.index_b;
        n_item.val = i_req.value;
        unique case (i_req.req_type)
            REQ_APPEND:    n_item.cmd = C_APPEND;
            REQ_PREPEND: begin
                n_item.cmd = C_INSERT;
                n_item.ia  = '0;
            end
            REQ_INSERT:    n_item.cmd = C_INSERT;
            REQ_OVERWRITE: n_item.cmd = C_OVERWRITE;
            REQ_SWAP:      n_item.cmd = C_SWAP;
            REQ_CLEAR:     n_item.cmd = C_CLEAR;
            REQ_READ:      n_item.cmd = C_READ;
            default:       n_item.cmd = C_BAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

/* rtl/core/ile_queue.sv */
// Short command queue between front and back of the indexed list engine.
// Depends on ile_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ile_queue import ile_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd_item i_item,
    input  logic      i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd_item o_head
);

    t_cmd_item        r_slot [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_AW:0]    r_cnt;
    logic [Q_AW:0]    n_cnt;

    assign o_full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    `ILE_ASSERT_IMPL(a_no_push_full, i_push, !o_full, "push into full queue")
    `ILE_ASSERT_IMPL(a_no_pop_empty, i_pop, !o_empty, "pop from empty queue")

endmodule

/* rtl/core/ile_back.sv */
// Back end of the indexed list engine: list store, count and the sequencer that runs commands.
// Depends on ile_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ile_back import ile_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cmd_item i_head,
    output logic      o_pop,
    output logic      o_done,
    output t_result   o_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW > 7) ? CW : 7;

    logic [31:0]   mem [CAPACITY];

    t_back_state   r_state;
    t_back_state   n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [AW-1:0] r_k;
    logic [AW-1:0] n_k;
    logic [6:0]    r_ia;
    logic [6:0]    r_ib;
    logic [31:0]   r_val;
    logic [31:0]   r_tmp;
    logic [31:0]   r_rdata;
    logic          r_done;
    t_result       r_res;
    t_result       n_res;

    logic          load;
    logic          tmp_ld;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic          fin;
    logic          ok;
    logic [31:0]   rd;

    logic [XW-1:0] cnt_x;
    logic [XW-1:0] hx_a;
    logic [XW-1:0] hx_b;
    logic [XW-1:0] rx_a;
    logic [XW-1:0] rx_a1;
    logic [XW-1:0] cap_x;
    logic [XW-1:0] cnt_nx;
    logic [AW-1:0] k_dn;
    logic [AW-1:0] k_up;

    assign cnt_x  = XW'(r_count);
    assign hx_a   = XW'(i_head.ia);
    assign hx_b   = XW'(i_head.ib);
    assign rx_a   = XW'(r_ia);
    assign rx_a1  = rx_a + 1'b1;
    assign cap_x  = XW'(CAPACITY);
    assign cnt_nx = XW'(n_count);
    assign k_dn   = r_k - 1'b1;
    assign k_up   = r_k + 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    unique case (i_head.cmd)
                        C_INSERT: begin
                            if (hx_a <= cnt_x) begin
                                if (cnt_x < cap_x) begin
                                    n_state = (cnt_x > hx_a) ? B_SHIFT_RD : B_PUT;
                                end
                            end else if (hx_a < cap_x) begin
                                n_state = B_FILL;
                            end
                        end
                        C_SWAP: begin
                            if (hx_a < cnt_x && hx_b < cnt_x) begin
                                n_state = B_SWAP_RB;
                            end
                        end
                        C_READ: begin
                            if (hx_a < cnt_x) begin
                                n_state = B_READ;
                            end
                        end
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_SHIFT_RD: n_state = B_SHIFT_WR;
            B_SHIFT_WR: n_state = (XW'(k_dn) == rx_a) ? B_PUT : B_SHIFT_RD;
            B_FILL:     n_state = (XW'(k_up) == rx_a) ? B_PUT : B_FILL;
            B_SWAP_RB:  n_state = B_SWAP_WA;
            B_SWAP_WA:  n_state = B_SWAP_WB;
            B_PUT,
            B_SWAP_WB,
            B_READ:     n_state = B_IDLE;
            default:    n_state = B_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_pop     = 1'b0;
        load      = 1'b0;
        tmp_ld    = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        n_count   = r_count;
        n_k       = r_k;
        fin       = 1'b0;
        ok        = 1'b0;
        rd        = '0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    load  = 1'b1;
                    unique case (i_head.cmd)
                        C_APPEND: begin
                            fin = 1'b1;
                            if (cnt_x < cap_x) begin
                                mem_we    = 1'b1;
                                mem_addr  = cnt_x[AW-1:0];
                                mem_wdata = i_head.val;
                                n_count   = r_count + 1'b1;
                                ok        = 1'b1;
                            end
                        end
                        C_INSERT: begin
                            if (hx_a <= cnt_x) begin
                                if (cnt_x < cap_x) begin
                                    n_k = cnt_x[AW-1:0];
                                end else begin
                                    fin = 1'b1;
                                end
                            end else if (hx_a < cap_x) begin
                                n_k = cnt_x[AW-1:0];
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        C_OVERWRITE: begin
                            fin = 1'b1;
                            if (hx_a < cnt_x) begin
                                mem_we    = 1'b1;
                                mem_addr  = hx_a[AW-1:0];
                                mem_wdata = i_head.val;
                                ok        = 1'b1;
                            end
                        end
                        C_SWAP: begin
                            if (hx_a < cnt_x && hx_b < cnt_x) begin
                                mem_re   = 1'b1;
                                mem_addr = hx_a[AW-1:0];
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        C_CLEAR: begin
                            fin     = 1'b1;
                            ok      = 1'b1;
                            n_count = '0;
                        end
                        C_READ: begin
                            if (hx_a < cnt_x) begin
                                mem_re   = 1'b1;
                                mem_addr = hx_a[AW-1:0];
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            B_SHIFT_RD: begin
                mem_re   = 1'b1;
                mem_addr = k_dn;
            end
            B_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_addr  = r_k;
                mem_wdata = r_rdata;
                n_k       = k_dn;
            end
            B_FILL: begin
                mem_we   = 1'b1;
                mem_addr = r_k;
                n_k      = k_up;
            end
            B_PUT: begin
                mem_we    = 1'b1;
                mem_addr  = rx_a[AW-1:0];
                mem_wdata = r_val;
                fin       = 1'b1;
                ok        = 1'b1;
                // past the end the count jumps to index + 1
                n_count   = (rx_a > cnt_x) ? rx_a1[CW-1:0] : r_count + 1'b1;
            end
            B_SWAP_RB: begin
                mem_re   = 1'b1;
                mem_addr = XW'(r_ib) == '0 ? '0 : AW'(r_ib);
                tmp_ld   = 1'b1;
            end
            B_SWAP_WA: begin
                mem_we    = 1'b1;
                mem_addr  = rx_a[AW-1:0];
                mem_wdata = r_rdata;
            end
            B_SWAP_WB: begin
                mem_we    = 1'b1;
                mem_addr  = AW'(r_ib);
                mem_wdata = r_tmp;
                fin       = 1'b1;
                ok        = 1'b1;
            end
            B_READ: begin
                fin = 1'b1;
                ok  = 1'b1;
                rd  = r_rdata;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_res.accepted      = ok;
        n_res.element_count = cnt_nx[6:0];
        n_res.is_empty      = (n_count == '0);
        n_res.read_value    = rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_k   <= n_k;
        if (load) begin
            r_ia  <= i_head.ia;
            r_ib  <= i_head.ib;
            r_val <= i_head.val;
        end
        if (tmp_ld) begin
            r_tmp <= r_rdata;
        end
    end

    // single-port store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `ILE_ASSERT(a_count_cap, XW'(r_count) <= cap_x, "list count above capacity")
    `ILE_ASSERT(a_one_port, !(mem_we && mem_re), "read and write on one port")
    `ILE_ASSERT_IMPL(a_shift_above, r_state == B_SHIFT_WR, XW'(r_k) > rx_a,
                     "shift pointer at or below target")
    `ILE_ASSERT_IMPL(a_pop_idle, o_pop, r_state == B_IDLE, "pop while busy")

endmodule
